/* sv/degree3_adjacency_table_assert.svh */
// Assertion macros for the checker file of the adjacency table.
`ifndef DEGREE3_ADJACENCY_TABLE_ASSERT_SVH
`define DEGREE3_ADJACENCY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define D3AT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adjacency table check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define D3AT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adjacency table check failed");

`endif

/* sv/d3at_pkg.sv */
// Types, codes and helpers of the degree-3 adjacency table.
package d3at_pkg;

  localparam int unsigned SLOTS  = 3;
  localparam int unsigned SLOT_W = 11;
  localparam int unsigned ROW_W  = SLOTS * SLOT_W;
  localparam int unsigned DEG_W  = 2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOTS-1:0][SLOT_W-1:0] row_t;

  localparam slot_t SEMI_MARK = 11'h400;

  // request codes
  localparam logic [2:0] REQ_HAS   = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_SEMI  = 3'd2;
  localparam logic [2:0] REQ_CUT   = 3'd3;
  localparam logic [2:0] REQ_JOIN  = 3'd4;
  localparam logic [2:0] REQ_COUNT = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SELF_LOOP = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NO_EDGE   = 3'd4;
  localparam logic [2:0] ST_NO_SEMI   = 3'd5;

  // result of one slot scan: first matching slot and number of matches
  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
    logic [1:0] cnt;
  } match_t;

  // Replace one slot of a row; an index past the last slot leaves it alone.
  function automatic row_t set_slot(input row_t row, input logic [1:0] idx,
                                    input slot_t val);
    row_t r;
    r = row;
    case (idx)
      2'd0:    r[0] = val;
      2'd1:    r[1] = val;
      2'd2:    r[2] = val;
      default: r = row;
    endcase
    return r;
  endfunction

endpackage

/* sv/d3at_ram.sv */
// Generic RAM: one write port, two registered read ports.
module d3at_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* sv/d3at_slot_match.sv */
// Slot matcher: compares the occupied slots of one row against a key.
module d3at_slot_match import d3at_pkg::*; (
  input  row_t             row_i,
  input  logic [DEG_W-1:0] deg_i,
  input  slot_t            key_i,
  output match_t           match_o
);

  always_comb begin
    logic hit;
    match_o = '0;
    // walk down so the lowest matching slot wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      hit = (2'(i) < deg_i) && (row_i[i] == key_i);
      if (hit) begin
        match_o.hit = 1'b1;
        match_o.idx = 2'(i);
      end
      match_o.cnt = match_o.cnt + {1'b0, hit};
    end
  end

endmodule

/* sv/degree3_adjacency_table.sv */
// Top level of the degree-3 adjacency table.
//
//   channel  direction  handshake                 payload
//   request  in         in_valid_i / in_stall_o   req_type_i, vertex_a_i, vertex_b_i
//   result   out        out_valid_o / out_stall_i status_o, edge_present_o, semi_count_o,
//                                                 vertex_count_o, edge_count_o
//
// A request runs in order: accept with row reads, four passes of the shared
// slot matcher, one decision step, a write step for each row on the single
// write port, and the result load. The matcher passes and the write port set its length.
// After reset a clearing pass over min(MAX_VERTICES, 1024) entries zeroes the
// degree memory; requests are stalled meanwhile. A stalled result holds in the
// output register; the next request waits for it only at its result load.
module degree3_adjacency_table import d3at_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [9:0]  vertex_a_i,
  input  logic [9:0]  vertex_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        edge_present_o,
  output logic [1:0]  semi_count_o,
  output logic [10:0] vertex_count_o,
  output logic [10:0] edge_count_o
);

  localparam int unsigned Depth = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [16:0] MaxV  = 17'(MAX_VERTICES);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WR_A   = 3'd4;
  localparam logic [2:0] S_WR_B   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    step_q, step_d;

  logic [2:0]  req_q;
  logic [9:0]  va_q, vb_q;
  logic [10:0] vt_q, et_q;

  match_t m_ab_q, m_ba_q, m_sa_q, m_sb_q;

  logic [2:0]       st_q;
  logic             present_q;
  logic [1:0]       semis_q;
  logic             wa_en_q, wb_en_q;
  row_t             row_a_new_q, row_b_new_q;
  logic [DEG_W-1:0] deg_a_new_q, deg_b_new_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic        out_present_q;
  logic [1:0]  out_semis_q;
  logic [10:0] out_vt_q, out_et_q;

  logic             accept;
  logic             out_free;
  logic [AW-1:0]    rd_addr_a, rd_addr_b;
  logic [ROW_W-1:0] row_a_bits, row_b_bits;
  row_t             row_a_rd, row_b_rd;
  logic [DEG_W-1:0] deg_a_rd, deg_b_rd;
  logic             row_we, deg_we;
  logic [AW-1:0]    wr_addr, deg_waddr;
  row_t             wr_row;
  logic [DEG_W-1:0] wr_deg, deg_wdata;

  row_t             mt_row;
  logic [DEG_W-1:0] mt_deg;
  slot_t            mt_key;
  match_t           mt_res;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // memories
  assign rd_addr_a = (state_q == S_IDLE) ? vertex_a_i[AW-1:0] : va_q[AW-1:0];
  assign rd_addr_b = (state_q == S_IDLE) ? vertex_b_i[AW-1:0] : vb_q[AW-1:0];

  assign row_we    = ((state_q == S_WR_A) && wa_en_q) || ((state_q == S_WR_B) && wb_en_q);
  assign wr_addr   = (state_q == S_WR_A) ? va_q[AW-1:0] : vb_q[AW-1:0];
  assign wr_row    = (state_q == S_WR_A) ? row_a_new_q : row_b_new_q;
  assign wr_deg    = (state_q == S_WR_A) ? deg_a_new_q : deg_b_new_q;
  assign deg_we    = row_we || (state_q == S_CLEAR);
  assign deg_waddr = (state_q == S_CLEAR) ? clr_q : wr_addr;
  assign deg_wdata = (state_q == S_CLEAR) ? '0 : wr_deg;

  d3at_ram #(.WIDTH(ROW_W), .DEPTH(Depth)) u_rows (
    .clk_i     (clk_i),
    .we_i      (row_we),
    .waddr_i   (wr_addr),
    .wdata_i   (ROW_W'(wr_row)),
    .raddr_a_i (rd_addr_a),
    .rdata_a_o (row_a_bits),
    .raddr_b_i (rd_addr_b),
    .rdata_b_o (row_b_bits)
  );

  d3at_ram #(.WIDTH(DEG_W), .DEPTH(Depth)) u_degs (
    .clk_i     (clk_i),
    .we_i      (deg_we),
    .waddr_i   (deg_waddr),
    .wdata_i   (deg_wdata),
    .raddr_a_i (rd_addr_a),
    .rdata_a_o (deg_a_rd),
    .raddr_b_i (rd_addr_b),
    .rdata_b_o (deg_b_rd)
  );

  assign row_a_rd = row_t'(row_a_bits);
  assign row_b_rd = row_t'(row_b_bits);

  // shared matcher: edge a->b, edge b->a, semi on a, semi on b
  always_comb begin
    mt_row = row_a_rd;
    mt_deg = deg_a_rd;
    mt_key = {1'b0, vb_q};
    unique case (step_q)
      2'd0: begin
        mt_row = row_a_rd;
        mt_deg = deg_a_rd;
        mt_key = {1'b0, vb_q};
      end
      2'd1: begin
        mt_row = row_b_rd;
        mt_deg = deg_b_rd;
        mt_key = {1'b0, va_q};
      end
      2'd2: begin
        mt_row = row_a_rd;
        mt_deg = deg_a_rd;
        mt_key = SEMI_MARK;
      end
      default: begin
        mt_row = row_b_rd;
        mt_deg = deg_b_rd;
        mt_key = SEMI_MARK;
      end
    endcase
  end

  d3at_slot_match u_match (
    .row_i   (mt_row),
    .deg_i   (mt_deg),
    .key_i   (mt_key),
    .match_o (mt_res)
  );

  // decision on the scan results
  logic             exists_a, exists_b, has_edge;
  logic [1:0]       semis_a, semis_b;
  logic [9:0]       hi;
  logic             hi_ok, b_ok;
  logic [10:0]      hi_top, b_top;
  logic [2:0]       dec_st;
  logic             dec_present;
  logic [1:0]       dec_semis;
  logic [10:0]      dec_vt, dec_et;
  logic             dec_wa, dec_wb;
  row_t             dec_row_a, dec_row_b;
  logic [DEG_W-1:0] dec_deg_a, dec_deg_b;

  assign exists_a = {1'b0, va_q} < vt_q;
  assign exists_b = {1'b0, vb_q} < vt_q;
  assign has_edge = exists_a && exists_b && m_ab_q.hit;
  assign semis_a  = exists_a ? m_sa_q.cnt : 2'd0;
  assign semis_b  = exists_b ? m_sb_q.cnt : 2'd0;
  assign hi       = (va_q > vb_q) ? va_q : vb_q;
  assign hi_ok    = {7'd0, hi} < MaxV;
  assign b_ok     = {7'd0, vb_q} < MaxV;
  assign hi_top   = {1'b0, hi} + 11'd1;
  assign b_top    = {1'b0, vb_q} + 11'd1;

  always_comb begin
    dec_st      = ST_OK;
    dec_present = 1'b0;
    dec_semis   = 2'd0;
    dec_vt      = vt_q;
    dec_et      = et_q;
    dec_wa      = 1'b0;
    dec_wb      = 1'b0;
    dec_row_a   = row_a_rd;
    dec_row_b   = row_b_rd;
    dec_deg_a   = deg_a_rd;
    dec_deg_b   = deg_b_rd;
    unique case (req_q)
      REQ_HAS: dec_present = has_edge;
      REQ_ADD: begin
        if (va_q == vb_q) begin
          dec_st = ST_SELF_LOOP;
        end else if (has_edge) begin
          dec_st = ST_EXISTS;
        end else if (!hi_ok) begin
          dec_st = ST_FULL;
        end else begin
          // growth stays even if a side turns out full
          if (hi_top > vt_q) dec_vt = hi_top;
          if ((deg_a_rd == 2'd3) || (deg_b_rd == 2'd3)) begin
            dec_st = ST_FULL;
          end else begin
            dec_wa    = 1'b1;
            dec_wb    = 1'b1;
            dec_row_a = set_slot(row_a_rd, deg_a_rd, {1'b0, vb_q});
            dec_row_b = set_slot(row_b_rd, deg_b_rd, {1'b0, va_q});
            dec_deg_a = deg_a_rd + 2'd1;
            dec_deg_b = deg_b_rd + 2'd1;
            dec_et    = et_q + 11'd1;
          end
        end
      end
      REQ_SEMI: begin
        if (!b_ok) begin
          dec_st = ST_FULL;
        end else begin
          if (b_top > vt_q) dec_vt = b_top;
          if (deg_b_rd == 2'd3) begin
            dec_st = ST_FULL;
          end else begin
            dec_wb    = 1'b1;
            dec_row_b = set_slot(row_b_rd, deg_b_rd, SEMI_MARK);
            dec_deg_b = deg_b_rd + 2'd1;
          end
        end
      end
      REQ_CUT: begin
        if (!has_edge) begin
          dec_st = ST_NO_EDGE;
        end else begin
          dec_wa    = 1'b1;
          dec_wb    = m_ba_q.hit;
          dec_row_a = set_slot(row_a_rd, m_ab_q.idx, SEMI_MARK);
          dec_row_b = set_slot(row_b_rd, m_ba_q.idx, SEMI_MARK);
          if (et_q != 11'd0) dec_et = et_q - 11'd1;
        end
      end
      REQ_JOIN: begin
        if (va_q == vb_q) begin
          dec_st = ST_SELF_LOOP;
        end else if (has_edge) begin
          dec_st = ST_EXISTS;
        end else if ((semis_a == 2'd0) || (semis_b == 2'd0)) begin
          dec_st = ST_NO_SEMI;
        end else begin
          dec_wa    = 1'b1;
          dec_wb    = 1'b1;
          dec_row_a = set_slot(row_a_rd, m_sa_q.idx, {1'b0, vb_q});
          dec_row_b = set_slot(row_b_rd, m_sb_q.idx, {1'b0, va_q});
          dec_et    = et_q + 11'd1;
        end
      end
      REQ_COUNT: dec_semis = semis_b;
      default: dec_st = ST_OK;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    step_d  = step_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        step_d = 2'd0;
        if (accept) state_d = S_SCAN;
      end
      S_SCAN: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = S_DECIDE;
      end
      S_DECIDE: state_d = S_WR_A;
      S_WR_A:   state_d = S_WR_B;
      S_WR_B:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      step_q      <= 2'd0;
      vt_q        <= 11'd0;
      et_q        <= 11'd0;
      wa_en_q     <= 1'b0;
      wb_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      step_q  <= step_d;
      if (state_q == S_DECIDE) begin
        vt_q    <= dec_vt;
        et_q    <= dec_et;
        wa_en_q <= dec_wa;
        wb_en_q <= dec_wb;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      va_q  <= vertex_a_i;
      vb_q  <= vertex_b_i;
    end
    if (state_q == S_SCAN) begin
      unique case (step_q)
        2'd0:    m_ab_q <= mt_res;
        2'd1:    m_ba_q <= mt_res;
        2'd2:    m_sa_q <= mt_res;
        default: m_sb_q <= mt_res;
      endcase
    end
    if (state_q == S_DECIDE) begin
      st_q        <= dec_st;
      present_q   <= dec_present;
      semis_q     <= dec_semis;
      row_a_new_q <= dec_row_a;
      row_b_new_q <= dec_row_b;
      deg_a_new_q <= dec_deg_a;
      deg_b_new_q <= dec_deg_b;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_status_q  <= st_q;
      out_present_q <= present_q;
      out_semis_q   <= semis_q;
      out_vt_q      <= vt_q;
      out_et_q      <= et_q;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign edge_present_o = out_present_q;
  assign semi_count_o   = out_semis_q;
  assign vertex_count_o = out_vt_q;
  assign edge_count_o   = out_et_q;

endmodule

/* sv/d3at_checker.sv */
// Port-level checks of the adjacency table, bound to its top level.
`include "degree3_adjacency_table_assert.svh"

module d3at_port_checks import d3at_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic        edge_present_o,
  input logic [1:0]  semi_count_o,
  input logic [10:0] vertex_count_o,
  input logic [10:0] edge_count_o
);

  logic [27:0] out_beat;
  assign out_beat = {status_o, edge_present_o, semi_count_o, vertex_count_o, edge_count_o};

  // a held result beat stays up and unchanged
  `D3AT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `D3AT_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_beat))
  // the block is busy right after taking a request beat
  `D3AT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // query answers only come with an ok status
  `D3AT_ASSERT_NOW(a_answer_ok, out_valid_o && (edge_present_o || (semi_count_o != 2'd0)), status_o == ST_OK)

endmodule

bind degree3_adjacency_table d3at_port_checks u_d3at_port_checks (.*);
